// ===== rtl/core/ttw_pkg.sv =====
package ttw_pkg;

  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;

  typedef struct packed {
    logic capture;
    logic zero_step;
    logic write_char;
    logic load_cell;
    logic clear_all;
    logic load_out;
  } ttw_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       row_valid;
    logic       read_ok;
    logic       sweep_last;
  } ttw_status_t;

endpackage

// ===== rtl/core/text_terminal_writer.sv =====
// Character terminal buffer of ROWS x COLUMNS bytes with a cursor. Each input beat carries
// an operation in s_axis_tuser (put character, clear screen, read cell) and returns exactly
// one output beat with the read byte, the cursor after the operation and a scroll flag.
// The block works on one beat at a time. A clear, an unknown operation or a read outside the
// screen or of a blank row goes from dispatch straight to the done state; any other read
// passes a RAM read wait state first, and a put a write state. A put zeroes the cursor
// row, one cell per cycle in the single-port character RAM, when that row is written for the
// first time since reset, a clear or the scroll that blanked it. The result is loaded in the
// done state once the output is free, and the next beat is accepted in the cycle after.
// Scrolling rotates a top-row offset, so it costs nothing extra; per-row valid bits make
// reset and clear immediate. A new beat is taken while the previous result still waits.
module text_terminal_writer import ttw_pkg::*; #(
  parameter int ROWS    = 24,
  parameter int COLUMNS = 80
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // char_code, read_row, read_column, zero pad
  input  logic [1:0]  s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // cell_value, cursor_row_out, cursor_column_out,
                                     // scrolled, zero pad
);

  ttw_cmd_t    cmd;
  ttw_status_t status;
  logic [7:0]  cell_value;
  logic [4:0]  cursor_row_out;
  logic [6:0]  cursor_column_out;
  logic        scrolled;

  ttw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ttw_dp #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .in_func           (s_axis_tuser),
    .in_char           (s_axis_tdata[7:0]),
    .in_row            (s_axis_tdata[12:8]),
    .in_column         (s_axis_tdata[19:13]),
    .cmd               (cmd),
    .status            (status),
    .cell_value        (cell_value),
    .cursor_row_out    (cursor_row_out),
    .cursor_column_out (cursor_column_out),
    .scrolled          (scrolled)
  );

  assign m_axis_tdata = {3'b000, scrolled, cursor_column_out, cursor_row_out, cell_value};

endmodule

// ===== rtl/core/ttw_ram.sv =====
module ttw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1920
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/ttw_ctrl.sv =====
module ttw_ctrl import ttw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  ttw_status_t status,
  output ttw_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_ZERO     = 3'd2;
  localparam logic [2:0] ST_WRITE    = 3'd3;
  localparam logic [2:0] ST_RD_WAIT  = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status.func)
          FUNC_PUT: begin
            state_next = status.row_valid ? ST_WRITE : ST_ZERO;
          end
          FUNC_CLEAR: begin
            cmd.clear_all = 1'b1;
            state_next    = ST_DONE;
          end
          FUNC_READ: begin
            state_next = status.read_ok ? ST_RD_WAIT : ST_DONE;
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_ZERO: begin
        cmd.zero_step = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.write_char = 1'b1;
        state_next     = ST_DONE;
      end
      ST_RD_WAIT: begin
        cmd.load_cell = 1'b1;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/ttw_dp.sv =====
module ttw_dp import ttw_pkg::*; #(
  parameter int ROWS    = 24,
  parameter int COLUMNS = 80
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_char,
  input  logic [4:0]  in_row,
  input  logic [6:0]  in_column,
  input  ttw_cmd_t    cmd,
  output ttw_status_t status,
  output logic [7:0]  cell_value,
  output logic [4:0]  cursor_row_out,
  output logic [6:0]  cursor_column_out,
  output logic        scrolled
);

  localparam int RW  = $clog2(ROWS);
  localparam int RW1 = RW + 1;
  localparam int CW  = $clog2(COLUMNS);
  localparam int AW  = $clog2(ROWS * COLUMNS);

  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
  localparam logic [RW:0]   ROWS_W   = RW1'(ROWS);
  localparam logic [6:0]    ROWS_IN  = 7'(ROWS);
  localparam logic [7:0]    COLS_IN  = 8'(COLUMNS);
  localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);

  logic [1:0]      func_q;
  logic [7:0]      char_q;
  logic [4:0]      rrow_q;
  logic [6:0]      rcol_q;
  logic [RW-1:0]   cur_row;
  logic [CW-1:0]   cur_col;
  logic [RW-1:0]   top;
  logic [ROWS-1:0] row_valid;
  logic [CW-1:0]   sweep;
  logic [7:0]      cell_q;
  logic            scrolled_q;

  logic            rd_in;
  logic [RW-1:0]   lrow;
  logic [RW:0]     row_sum;
  logic [RW-1:0]   prow;
  logic [CW-1:0]   col;
  logic [AW-1:0]   addr;
  logic            we;
  logic [7:0]      wdata;
  logic [7:0]      rdata;
  logic            next_line;
  logic            scroll;

  assign rd_in = ({2'b00, rrow_q} < ROWS_IN) && ({1'b0, rcol_q} < COLS_IN);

  // logical to physical row through the rotating top offset
  assign lrow    = (func_q == FUNC_READ) ? RW'(rrow_q) : cur_row;
  assign row_sum = {1'b0, top} + {1'b0, lrow};
  assign prow    = (row_sum >= ROWS_W) ? RW'(row_sum - ROWS_W) : RW'(row_sum);

  always_comb begin
    if (cmd.zero_step) begin
      col = sweep;
    end else if (func_q == FUNC_READ) begin
      col = CW'(rcol_q);
    end else begin
      col = cur_col;
    end
  end

  assign addr  = AW'(prow) * COLS_A + AW'(col);
  assign we    = cmd.zero_step | cmd.write_char;
  assign wdata = cmd.write_char ? char_q : 8'h00;

  ttw_ram #(
    .WIDTH (8),
    .DEPTH (ROWS * COLUMNS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  assign next_line = (char_q == NEWLINE_CODE) || (cur_col == COL_LAST);
  assign scroll    = cmd.write_char && next_line && (cur_row == ROW_LAST);

  assign status.func       = func_q;
  assign status.row_valid  = row_valid[prow];
  assign status.read_ok    = rd_in && row_valid[prow];
  assign status.sweep_last = (sweep == COL_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row   <= '0;
      cur_col   <= '0;
      top       <= '0;
      row_valid <= '0;
    end else if (cmd.clear_all) begin
      cur_row   <= '0;
      cur_col   <= '0;
      top       <= '0;
      row_valid <= '0;
    end else if (cmd.write_char) begin
      row_valid[prow] <= 1'b1;
      if (next_line) begin
        cur_col <= '0;
        if (cur_row == ROW_LAST) begin
          // old top row becomes the new bottom row, left blank
          top            <= (top == ROW_LAST) ? '0 : top + 1'b1;
          row_valid[top] <= 1'b0;
        end else begin
          cur_row <= cur_row + 1'b1;
        end
      end else begin
        cur_col <= cur_col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q     <= in_func;
      char_q     <= in_char;
      rrow_q     <= in_row;
      rcol_q     <= in_column;
      sweep      <= '0;
      cell_q     <= 8'h00;
      scrolled_q <= 1'b0;
    end else begin
      if (cmd.zero_step) begin
        sweep <= sweep + 1'b1;
      end
      if (scroll) begin
        scrolled_q <= 1'b1;
      end
      if (cmd.load_cell) begin
        cell_q <= rdata;
      end
    end
    if (cmd.load_out) begin
      cell_value        <= cell_q;
      cursor_row_out    <= 5'(cur_row);
      cursor_column_out <= 7'(cur_col);
      scrolled          <= scrolled_q;
    end
  end

endmodule
